[rtl/bca_pkg.sv]
// Package for the binned covariance accumulator: opcodes, register indexes,
// the queue entry type and the back-end state type. No dependencies.
`timescale 1ns / 1ps
package bca_pkg;
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    localparam logic [1:0] REG_FIRST_COMPONENTS  = 2'd0;
    localparam logic [1:0] REG_SECOND_COMPONENTS = 2'd1;
    localparam logic [1:0] REG_PLANE_RECIPROCAL  = 2'd2;
    localparam logic [1:0] REG_LINE_CELLS        = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIFF,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_WRITE,
        ST_CLEAR
    } back_state_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        mode_t        mode;
        logic         bin_ok;
        logic         sel_ok;
        logic [15:0]  bin;
        logic [3:0]   sel;
        logic [1:0]   fc;
        logic [1:0]   sc;
        logic [2:0][32:0] fv;
        logic [2:0][32:0] sv;
    } entry_t;
endpackage

[rtl/bca_front.sv]
// Front end: holds configuration, classifies items and queues them.
// Depends on bca_pkg.
`timescale 1ns / 1ps
module bca_front #(
    parameter int MAX_BINS       = 1024,
    parameter int MAX_COMPONENTS = 3,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [9:0]          bin_index,
    input  logic [3:0]          moment_select,
    input  logic [95:0]         first_vec,
    input  logic [95:0]         second_vec,
    output logic [31:0]         recip,
    output logic                q_valid,
    output bca_pkg::entry_t     q_entry,
    input  logic                q_pop
);
    localparam int QD = 2;
    logic [1:0]  fc_reg, sc_reg;
    logic [31:0] recip_reg;
    logic [10:0] cells_reg;
    bca_pkg::entry_t q_reg [QD];
    logic        q_wp_reg, q_rp_reg;
    logic [1:0]  q_cnt_reg;
    logic [1:0]  fc_use, sc_use;
    logic [16:0] cells_use;
    bca_pkg::entry_t e;
    logic push;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fc_reg    <= 2'd3;
            sc_reg    <= 2'd3;
            recip_reg <= 32'hFFFF_FFFF;
            cells_reg <= 11'd1024;
        end else if (cfg_write) begin
            unique case (cfg_index)
                bca_pkg::REG_FIRST_COMPONENTS:  fc_reg    <= cfg_data[1:0];
                bca_pkg::REG_SECOND_COMPONENTS: sc_reg    <= cfg_data[1:0];
                bca_pkg::REG_PLANE_RECIPROCAL:  recip_reg <= cfg_data;
                bca_pkg::REG_LINE_CELLS:        cells_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        fc_use = (fc_reg == 2'd0) ? 2'd1 :
                 (32'(fc_reg) > MAX_COMPONENTS) ? 2'(MAX_COMPONENTS) : fc_reg;
        sc_use = (sc_reg == 2'd0) ? 2'd1 :
                 (32'(sc_reg) > MAX_COMPONENTS) ? 2'(MAX_COMPONENTS) : sc_reg;
        cells_use = (cells_reg == 11'd0) ? 17'd1 :
                    (32'(cells_reg) > MAX_BINS) ? 17'(MAX_BINS) : 17'(cells_reg);
        e.mode   = bca_pkg::mode_t'(mode);
        e.bin    = 16'(bin_index);
        e.sel    = moment_select;
        e.fc     = fc_use;
        e.sc     = sc_use;
        e.bin_ok = 17'(bin_index) < cells_use;
        e.sel_ok = 5'(moment_select) < 5'(fc_use) * 5'(sc_use);
        for (int i = 0; i < 3; i++) begin
            e.fv[i] = 33'(signed'(first_vec[i*32 +: VALUE_WIDTH]));
            e.sv[i] = 33'(signed'(second_vec[i*32 +: VALUE_WIDTH]));
        end
    end

    assign busy    = (q_cnt_reg == 2'(QD));
    assign push    = start && !busy;
    assign q_valid = (q_cnt_reg != 2'd0);
    assign q_entry = q_reg[q_rp_reg];
    assign recip   = recip_reg;

    always_ff @(posedge clk) begin
        if (push) q_reg[q_wp_reg] <= e;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end else begin
            if (push) q_wp_reg <= ~q_wp_reg;
            if (q_pop) q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

[rtl/bca_back.sv]
// Back end: mean and moment memories, multiply and saturating accumulate.
// Depends on bca_pkg.
`timescale 1ns / 1ps
module bca_back #(
    parameter int MAX_BINS       = 1024,
    parameter int MAX_COMPONENTS = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     recip,
    input  logic            q_valid,
    input  bca_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            done,
    output logic [63:0]     moment_value,
    output logic [9:0]      read_bin,
    output logic            range_error
);
    localparam int SLOTS = MAX_COMPONENTS * MAX_COMPONENTS;
    localparam int SDEP  = MAX_BINS * SLOTS;
    localparam int SAW   = $clog2(SDEP);
    localparam int BW    = $clog2(MAX_BINS);

    // Each mean entry holds the whole vector of one bin, so a load is one write.
    logic [MAX_COMPONENTS-1:0][31:0] fmean_mem [MAX_BINS];
    logic [MAX_COMPONENTS-1:0][31:0] smean_mem [MAX_BINS];
    logic [63:0] sum_mem   [SDEP];

    bca_pkg::back_state_t state_reg, state_next;
    bca_pkg::entry_t cur_reg;
    logic [1:0]  m_reg, n_reg, m_next, n_next;
    logic [3:0]  k_reg, k_next;
    logic [SAW:0] wipe_reg;
    logic        wiping;
    logic [MAX_COMPONENTS-1:0][31:0] fm_rd_reg, sm_rd_reg;
    logic [MAX_COMPONENTS-1:0][31:0] fm_wr, sm_wr;
    logic [63:0] sum_rd_reg;
    logic [32:0] d1_reg, d2_reg;
    logic        neg_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [95:0] mag_reg;
    logic [63:0] res_reg;
    logic        done_reg, rerr_reg;
    logic [9:0]  rbin_reg;

    logic [BW-1:0] bin;
    logic [SAW-1:0] slot_addr;
    logic [63:0] term, sum_sat;
    logic [64:0] sum_wide;
    logic [32:0] a1, a2;
    logic        take;

    assign bin     = cur_reg.bin[BW-1:0];
    assign slot_addr = (state_reg == bca_pkg::ST_CLEAR) ?
        SAW'(bin) * SAW'(SLOTS) + SAW'(k_reg) :
        (cur_reg.mode == bca_pkg::MODE_READ) ?
        SAW'(bin) * SAW'(SLOTS) + SAW'(cur_reg.sel) :
        SAW'(bin) * SAW'(SLOTS) + SAW'(m_reg) * SAW'(cur_reg.sc) + SAW'(n_reg);
    assign wiping   = (wipe_reg < (SAW+1)'(SDEP));
    assign take     = (state_reg == bca_pkg::ST_IDLE) && q_valid && !wiping;
    assign q_pop    = take;

    // Magnitudes of the two fluctuations for the unsigned products.
    assign a1 = d1_reg[32] ? -d1_reg : d1_reg;
    assign a2 = d2_reg[32] ? -d2_reg : d2_reg;

    always_comb begin
        for (int i = 0; i < MAX_COMPONENTS; i++) begin
            fm_wr[i] = cur_reg.fv[i][31:0];
            sm_wr[i] = cur_reg.sv[i][31:0];
        end
    end

    always_comb begin
        if (neg_reg) term = (mag_reg[95:63] != 33'd0) ? 64'h8000_0000_0000_0000
                                                    : -mag_reg[63:0];
        else         term = (mag_reg[95:63] != 33'd0) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                    : mag_reg[63:0];
        sum_wide = {sum_rd_reg[63], sum_rd_reg} + {term[63], term};
        if (sum_wide[64] != sum_wide[63])
            sum_sat = sum_wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
            sum_sat = sum_wide[63:0];
    end

    always_comb begin
        state_next = state_reg;
        m_next = m_reg;
        n_next = n_reg;
        k_next = k_reg;
        unique case (state_reg)
            bca_pkg::ST_IDLE:  if (take) state_next = bca_pkg::ST_FETCH;
            bca_pkg::ST_FETCH: begin
                if (!cur_reg.bin_ok) state_next = (cur_reg.mode == bca_pkg::MODE_READ)
                                     ? bca_pkg::ST_WRITE : bca_pkg::ST_IDLE;
                else unique case (cur_reg.mode)
                    bca_pkg::MODE_LOAD:   state_next = bca_pkg::ST_IDLE;
                    bca_pkg::MODE_SAMPLE: state_next = bca_pkg::ST_DIFF;
                    bca_pkg::MODE_READ:   state_next = bca_pkg::ST_WRITE;
                    bca_pkg::MODE_CLEAR:  state_next = bca_pkg::ST_CLEAR;
                    default:              state_next = bca_pkg::ST_IDLE;
                endcase
            end
            bca_pkg::ST_DIFF:  state_next = bca_pkg::ST_MUL_A;
            bca_pkg::ST_MUL_A: state_next = bca_pkg::ST_MUL_B;
            bca_pkg::ST_MUL_B: state_next = bca_pkg::ST_MUL_C;
            bca_pkg::ST_MUL_C: state_next = bca_pkg::ST_WRITE;
            bca_pkg::ST_WRITE: begin
                if (cur_reg.mode == bca_pkg::MODE_READ) state_next = bca_pkg::ST_IDLE;
                else if (n_reg + 2'd1 < cur_reg.sc) begin
                    n_next = n_reg + 2'd1;
                    state_next = bca_pkg::ST_FETCH;
                end else if (m_reg + 2'd1 < cur_reg.fc) begin
                    n_next = 2'd0;
                    m_next = m_reg + 2'd1;
                    state_next = bca_pkg::ST_FETCH;
                end else state_next = bca_pkg::ST_IDLE;
            end
            bca_pkg::ST_CLEAR: begin
                k_next = k_reg + 4'd1;
                if (32'(k_reg) == SLOTS - 1) state_next = bca_pkg::ST_IDLE;
            end
            default: state_next = bca_pkg::ST_IDLE;
        endcase
        if (take) begin
            m_next = 2'd0;
            n_next = 2'd0;
            k_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bca_pkg::ST_IDLE;
            m_reg     <= 2'd0;
            n_reg     <= 2'd0;
            k_reg     <= 4'd0;
            wipe_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_reg     <= m_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            if (wiping) wipe_reg <= wipe_reg + 1'b1;
            done_reg  <= (state_reg == bca_pkg::ST_WRITE) &&
                         (cur_reg.mode == bca_pkg::MODE_READ);
        end
    end

    // Memories and datapath. A sample slot runs fetch, difference, three
    // multiply steps and the saturating write; a read runs fetch then write.
    always_ff @(posedge clk) begin
        if (take) cur_reg <= q_entry;
        fm_rd_reg  <= fmean_mem[bin];
        sm_rd_reg  <= smean_mem[bin];
        sum_rd_reg <= sum_mem[slot_addr];
        if (wiping) sum_mem[wipe_reg[SAW-1:0]] <= 64'd0;
        else if (state_reg == bca_pkg::ST_CLEAR) sum_mem[slot_addr] <= 64'd0;
        else if (state_reg == bca_pkg::ST_WRITE && cur_reg.mode == bca_pkg::MODE_SAMPLE)
            sum_mem[slot_addr] <= sum_sat;
        if (state_reg == bca_pkg::ST_FETCH && cur_reg.bin_ok &&
            cur_reg.mode == bca_pkg::MODE_LOAD) begin
            fmean_mem[bin] <= fm_wr;
            smean_mem[bin] <= sm_wr;
        end
        d1_reg  <= cur_reg.fv[m_reg] - {fm_rd_reg[m_reg][31], fm_rd_reg[m_reg]};
        d2_reg  <= cur_reg.sv[n_reg] - {sm_rd_reg[n_reg][31], sm_rd_reg[n_reg]};
        if (state_reg == bca_pkg::ST_MUL_A) begin
            neg_reg <= d1_reg[32] ^ d2_reg[32];
            lo_reg  <= 64'(a1[31:0]) * 64'(a2[31:0]);
            hi_reg  <= 64'(a1[31:0]) * 64'(a2[32]) + 64'(a2[31:0]) * 64'(a1[32]);
        end
        if (state_reg == bca_pkg::ST_MUL_B) begin
            // Full product is hi_reg * 2^32 + lo_reg (66 bits); keep in lo/hi.
            lo_reg  <= 64'(lo_reg[31:0]) * 64'(recip);
            hi_reg  <= 64'(lo_reg[63:32] + hi_reg[31:0]) * 64'(recip);
            mag_reg <= 96'({1'b0, hi_reg[32] | (lo_reg[63:32] + hi_reg[31:0] < lo_reg[63:32])});
        end
        if (state_reg == bca_pkg::ST_MUL_C)
            mag_reg <= 96'(lo_reg[63:32]) + 96'(hi_reg) + ({64'd0, mag_reg[31:0]} * 96'(recip) << 64);
        if (state_reg == bca_pkg::ST_WRITE) begin
            rerr_reg <= !(cur_reg.bin_ok && cur_reg.sel_ok);
            res_reg  <= (cur_reg.bin_ok && cur_reg.sel_ok) ? sum_rd_reg : 64'd0;
            rbin_reg <= cur_reg.bin[9:0];
        end
    end

    assign done         = done_reg;
    assign moment_value = res_reg;
    assign read_bin     = rbin_reg;
    assign range_error  = rerr_reg;
endmodule

[rtl/binned_covariance_accumulator_unit.sv]
// Top level of the binned covariance accumulator.
// Depends on bca_pkg, bca_front and bca_back.
//
//  channel | signals                                  | handshake
//  config  | cfg_write, cfg_index, cfg_data           | taken when cfg_write high
//  item    | mode, bin_index, moment_select, values   | start high, busy low
//  result  | moment_value, read_bin, range_error      | done strobe, one cycle
//
// A sample runs fetch, difference, the multiply states and write per component
// pair, then idle; a read runs fetch and write; a clear runs fetch and a clear
// step per slot; a load writes the means in fetch. A read result is registered
// after write. After reset the moment memory is swept to zero, one entry a cycle,
// all MAX_BINS*MAX_COMPONENTS^2 entries (9216 by default); items queue meanwhile.
// A two-entry queue parts front and back; the receiver cannot stall results.
`timescale 1ns / 1ps
module binned_covariance_accumulator_unit #(
    parameter int MAX_BINS       = 1024,
    parameter int MAX_COMPONENTS = 3,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [9:0]         bin_index,
    input  logic [3:0]         moment_select,
    input  logic signed [31:0] first_value_a,
    input  logic signed [31:0] first_value_b,
    input  logic signed [31:0] first_value_c,
    input  logic signed [31:0] second_value_a,
    input  logic signed [31:0] second_value_b,
    input  logic signed [31:0] second_value_c,
    output logic               done,
    output logic signed [63:0] moment_value,
    output logic [9:0]         read_bin,
    output logic               range_error
);
    logic            q_valid, q_pop;
    bca_pkg::entry_t q_entry;
    logic [31:0]     recip;

    bca_front #(.MAX_BINS(MAX_BINS), .MAX_COMPONENTS(MAX_COMPONENTS),
                .VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .mode(mode),
        .bin_index(bin_index), .moment_select(moment_select),
        .first_vec({first_value_c, first_value_b, first_value_a}),
        .second_vec({second_value_c, second_value_b, second_value_a}),
        .recip(recip), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
    );

    bca_back #(.MAX_BINS(MAX_BINS), .MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
        .clk(clk), .rst_n(rst_n), .recip(recip), .q_valid(q_valid),
        .q_entry(q_entry), .q_pop(q_pop), .done(done),
        .moment_value(moment_value), .read_bin(read_bin),
        .range_error(range_error)
    );
endmodule
